// ----- rtl/core/ttmm_pkg.sv -----
// shared constants and types for the touch trimmed mean mapper
package ttmm_pkg;

	// default raw sample width
	localparam int SAMPLE_BITS_DEF = 12;

	// window of pairs, one min and one max dropped, eight kept
	localparam int WINDOW_PAIRS = 10;
	localparam int KEPT_SHIFT   = 3;
	localparam int CNT_W        = $clog2(WINDOW_PAIRS);

	// calibration formats
	localparam int GAIN_W       = 18;
	localparam int OFFSET_W     = 17;
	localparam int FRAC_BITS    = 16;
	localparam int OFFSET_SHIFT = 12;
	localparam int PIXEL_W      = 10;

	// configuration port
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;

	localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = 18'sd65536;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd0;

	// control shared by the lanes
	typedef struct packed {
		logic take;   // pair transfer this cycle
		logic last;   // the transfer closes the window
		logic en;     // result pipeline advances
	} lane_ctl_t;

endpackage

// ----- rtl/core/touch_trimmed_mean_mapper.sv -----
// Touch trimmed mean mapper. Takes one (x, y) sample pair per clock on the input channel;
// every tenth pair closes a window, whose mapped pixel pair then moves through the result
// pipeline into the output register. Non-closing pairs are always taken at one per
// cycle; the closing pair is held off only while the four-stage result pipeline
// (window capture, trimmed mean, gain multiply, output register) is stalled by the output
// side. Calibration writes take effect on the next closing pair and must be made while
// the block is idle.
module touch_trimmed_mean_mapper #(
	parameter int SAMPLE_BITS = ttmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [ttmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ttmm_pkg::CFG_W-1:0]       cfg_data,
	// sample pairs
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [SAMPLE_BITS-1:0]           x_sample,
	input  logic [SAMPLE_BITS-1:0]           y_sample,
	// pixel pairs
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ttmm_pkg::PIXEL_W-1:0]     screen_x,
	output logic [ttmm_pkg::PIXEL_W-1:0]     screen_y
);
	import ttmm_pkg::*;

	logic signed [GAIN_W-1:0]   gain_x_q;
	logic signed [OFFSET_W-1:0] offset_x_q;
	logic signed [GAIN_W-1:0]   gain_y_q;
	logic signed [OFFSET_W-1:0] offset_y_q;

	logic [CNT_W-1:0] cnt_q;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             out_valid_q;
	logic             en;
	logic             last;
	lane_ctl_t        ctl;

	logic [SAMPLE_BITS-1:0] mean_x_s2;
	logic [SAMPLE_BITS-1:0] mean_y_s2;
	logic [PIXEL_W-1:0]     pix_x;
	logic [PIXEL_W-1:0]     pix_y;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q   <= GAIN_RESET;
			offset_x_q <= OFFSET_RESET;
			gain_y_q   <= GAIN_RESET;
			offset_y_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_X:   gain_x_q   <= cfg_data[GAIN_W-1:0];
				REG_OFFSET_X: offset_x_q <= cfg_data[OFFSET_W-1:0];
				REG_GAIN_Y:   gain_y_q   <= cfg_data[GAIN_W-1:0];
				REG_OFFSET_Y: offset_y_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake and lane control
	assign en       = !out_valid_q || out_ready;
	assign last     = (cnt_q == CNT_W'(WINDOW_PAIRS - 1));
	assign in_ready = !last || en;

	always_comb begin
		ctl.take = in_valid && in_ready;
		ctl.last = last;
		ctl.en   = en;
	end

	// window pair counter and result pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.take) begin
				cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
			end
			if (en) begin
				v_s1        <= ctl.take && last;
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				out_valid_q <= v_s3;
			end
		end
	end

	// axis lanes
	ttmm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sample  (x_sample),
		.mean_s2 (mean_x_s2)
	);

	ttmm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sample  (y_sample),
		.mean_s2 (mean_y_s2)
	);

	ttmm_map #(.SAMPLE_BITS(SAMPLE_BITS)) u_map_x (
		.clk    (clk),
		.en     (en),
		.gain   (gain_x_q),
		.offset (offset_x_q),
		.mean   (mean_x_s2),
		.pixel  (pix_x)
	);

	ttmm_map #(.SAMPLE_BITS(SAMPLE_BITS)) u_map_y (
		.clk    (clk),
		.en     (en),
		.gain   (gain_y_q),
		.offset (offset_y_q),
		.mean   (mean_y_s2),
		.pixel  (pix_y)
	);

	// merge both axes into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			screen_x <= pix_x;
			screen_y <= pix_y;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/ttmm_lane.sv -----
// one axis lane: running sum, minimum and maximum, then the trimmed mean
module ttmm_lane #(
	parameter int SAMPLE_BITS = ttmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ttmm_pkg::lane_ctl_t    ctl,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SAMPLE_BITS-1:0] mean_s2
);
	import ttmm_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + 4;

	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;

	logic [SUM_W-1:0]       sum_nxt;
	logic [SAMPLE_BITS-1:0] min_nxt;
	logic [SAMPLE_BITS-1:0] max_nxt;

	logic [SUM_W-1:0]       sum_s1;
	logic [SAMPLE_BITS-1:0] min_s1;
	logic [SAMPLE_BITS-1:0] max_s1;
	logic [SUM_W-1:0]       kept;

	// window statistics including the incoming sample
	always_comb begin
		sum_nxt = sum_q + SUM_W'(sample);
		min_nxt = (sample < min_q) ? sample : min_q;
		max_nxt = (sample > max_q) ? sample : max_q;
	end

	// running window state, cleared when the window closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
		end else if (ctl.take) begin
			if (ctl.last) begin
				sum_q <= '0;
				min_q <= '1;
				max_q <= '0;
			end else begin
				sum_q <= sum_nxt;
				min_q <= min_nxt;
				max_q <= max_nxt;
			end
		end
	end

	// capture the closed window
	always_ff @(posedge clk) begin
		if (ctl.take && ctl.last) begin
			sum_s1 <= sum_nxt;
			min_s1 <= min_nxt;
			max_s1 <= max_nxt;
		end
	end

	// drop one extreme each side, mean of the eight left
	assign kept = sum_s1 - SUM_W'(min_s1) - SUM_W'(max_s1);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			mean_s2 <= kept[KEPT_SHIFT +: SAMPLE_BITS];
		end
	end

endmodule

// ----- rtl/core/ttmm_map.sv -----
// one axis mapper: gain times mean plus offset, truncated and clamped to a pixel
module ttmm_map #(
	parameter int SAMPLE_BITS = ttmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     en,
	input  logic signed [ttmm_pkg::GAIN_W-1:0]       gain,
	input  logic signed [ttmm_pkg::OFFSET_W-1:0]     offset,
	input  logic [SAMPLE_BITS-1:0]                   mean,
	output logic [ttmm_pkg::PIXEL_W-1:0]             pixel
);
	import ttmm_pkg::*;

	localparam int MUL_W  = GAIN_W + SAMPLE_BITS + 1;
	localparam int OFS_W  = OFFSET_W + OFFSET_SHIFT;
	localparam int PROD_W = ((MUL_W > OFS_W) ? MUL_W : OFS_W) + 1;

	logic signed [SAMPLE_BITS:0] mean_ext;
	logic signed [PROD_W-1:0]    prod_s3;

	assign mean_ext = {1'b0, mean};

	// exact value in units of 2^-16 pixel
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(gain) * PROD_W'(mean_ext)
				+ (PROD_W'(offset) <<< OFFSET_SHIFT);
		end
	end

	// negative gives zero, past the screen gives the last pixel
	always_comb begin
		if (prod_s3[PROD_W-1]) begin
			pixel = '0;
		end else if (|prod_s3[PROD_W-2:FRAC_BITS+PIXEL_W]) begin
			pixel = '1;
		end else begin
			pixel = prod_s3[FRAC_BITS +: PIXEL_W];
		end
	end

endmodule

// ----- rtl/core/ttmm_checker.sv -----
// port level checks for the touch trimmed mean mapper, bound to the top level
module ttmm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ttmm_pkg::PIXEL_W-1:0] screen_x,
	input logic [ttmm_pkg::PIXEL_W-1:0] screen_y
);
	import ttmm_pkg::*;

	logic [CNT_W-1:0] seen_q;
	logic [2:0]       pend_q;
	logic             in_xfer;
	logic             out_xfer;
	logic             closes;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign closes   = in_xfer && (seen_q == CNT_W'(WINDOW_PAIRS - 1));

	// pairs seen in the window and results owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			pend_q <= '0;
		end else begin
			if (in_xfer) begin
				seen_q <= closes ? '0 : seen_q + CNT_W'(1);
			end
			pend_q <= pend_q + 3'(closes) - 3'(out_xfer);
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y))
		else $error("stalled result changed");

	// no result without a closed window
	a_out_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 3'd0)
		else $error("result without a closed window");

	// input never blocked while the output register is empty
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// results in flight never exceed the pipeline depth
	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("too many results in flight");

	// mid-window pairs are never held off
	a_mid_window: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != CNT_W'(WINDOW_PAIRS - 1) |-> in_ready)
		else $error("mid-window pair stalled");

endmodule

bind touch_trimmed_mean_mapper ttmm_checker u_ttmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.screen_x  (screen_x),
	.screen_y  (screen_y)
);

// ----- dv/tb_touch_trimmed_mean_mapper.sv -----
// testbench for the touch trimmed mean mapper: directed table, random windows, scoreboard
`timescale 1ns / 1ps

module tb_touch_trimmed_mean_mapper;
	import ttmm_pkg::*;

	localparam int RAND_PAIRS  = 450;
	localparam int CALM_PAIRS  = 70;      // tail of the run with no idling
	localparam int IDLE_PAD    = 8;       // past the four-stage result pipeline
	localparam int CYCLE_LIMIT = 200000;
	localparam int PIXEL_MAX   = 1023;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

	typedef enum logic {ROW_PAIR, ROW_REG} row_kind_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] px;
		logic [PIXEL_W-1:0] py;
	} pixel_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [11:0]          sx;
		logic [11:0]          sy;
		bit                   typed;
		logic [PIXEL_W-1:0]   tx;
		logic [PIXEL_W-1:0]   ty;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [11:0]          x_sample;
	logic [11:0]          y_sample;
	logic                 out_valid;
	logic                 out_ready;
	logic [PIXEL_W-1:0]   screen_x;
	logic [PIXEL_W-1:0]   screen_y;

	// calibration as the block should hold it
	logic signed [GAIN_W-1:0]   cal_gain_x = GAIN_RESET;
	logic signed [OFFSET_W-1:0] cal_off_x  = OFFSET_RESET;
	logic signed [GAIN_W-1:0]   cal_gain_y = GAIN_RESET;
	logic signed [OFFSET_W-1:0] cal_off_y  = OFFSET_RESET;

	// window being collected
	int          win_pairs = 0;
	logic [15:0] win_sum_x = '0;
	logic [15:0] win_sum_y = '0;
	logic [11:0] win_min_x = '1;
	logic [11:0] win_min_y = '1;
	logic [11:0] win_max_x = '0;
	logic [11:0] win_max_y = '0;

	pixel_t    pixel_q[$];
	plan_row_t plan[$];
	int        mismatches = 0;
	int        cycles = 0;
	int        src_rate = 0;
	int        sink_rate = 0;
	int        hold_left = 0;

	touch_trimmed_mean_mapper DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_sample  (x_sample),
		.y_sample  (y_sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.screen_x  (screen_x),
		.screen_y  (screen_y)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// gain times mean plus offset, in 2^-16 pixel, truncated and clamped
	function automatic logic [PIXEL_W-1:0] to_pixel(input logic [11:0] mean,
			input logic signed [GAIN_W-1:0] gain, input logic signed [OFFSET_W-1:0] offset);
		longint acc;
		acc = longint'(gain) * longint'({1'b0, mean}) + longint'(offset) * 4096;
		if (acc < 0)
			return '0;
		acc = acc >>> FRAC_BITS;
		if (acc > PIXEL_MAX)
			return PIXEL_W'(PIXEL_MAX);
		return acc[PIXEL_W-1:0];
	endfunction

	// accumulate one pair; on the tenth, drop min and max, average the rest and map
	function automatic bit trim_and_map(input logic [11:0] sx, sy, output pixel_t res);
		logic [15:0] mean_x;
		logic [15:0] mean_y;
		res = '0;
		win_sum_x += 16'(sx);
		win_sum_y += 16'(sy);
		if (sx < win_min_x) win_min_x = sx;
		if (sx > win_max_x) win_max_x = sx;
		if (sy < win_min_y) win_min_y = sy;
		if (sy > win_max_y) win_max_y = sy;
		win_pairs++;
		if (win_pairs < WINDOW_PAIRS)
			return 1'b0;
		mean_x = (win_sum_x - win_min_x - win_max_x) >> KEPT_SHIFT;
		mean_y = (win_sum_y - win_min_y - win_max_y) >> KEPT_SHIFT;
		res.px = to_pixel(mean_x[11:0], cal_gain_x, cal_off_x);
		res.py = to_pixel(mean_y[11:0], cal_gain_y, cal_off_y);
		win_pairs = 0;
		win_sum_x = '0;
		win_sum_y = '0;
		win_min_x = '1;
		win_min_y = '1;
		win_max_x = '0;
		win_max_y = '0;
		return 1'b1;
	endfunction

	function automatic void add_pair(input logic [11:0] sx, sy, input bit typed = 1'b0,
			input logic [PIXEL_W-1:0] tx = 10'd0, ty = 10'd0);
		plan.push_back('{ROW_PAIR, REG_GAIN_X, 18'd0, sx, sy, typed, tx, ty});
	endfunction

	function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		plan.push_back('{ROW_REG, idx, data, 12'd0, 12'd0, 1'b0, 10'd0, 10'd0});
	endfunction

	// raw sample: uniform, clustered round a touch point, or piled on a few values
	function automatic logic [11:0] draw_sample(input int mode, base, spread);
		int v;
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
		case (mode)
			0: v = $urandom_range(0, 4095);
			1: v = base + int'($urandom_range(0, 2 * spread)) - spread;
			default: begin
				case ($urandom_range(0, 3))
					0: v = 0;
					1: v = 4095;
					default: v = base;
				endcase
			end
		endcase
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[11:0];
	endfunction

	// offer one pair, wait for its transfer, then maybe leave a gap
	task automatic send_pair(input logic [11:0] sx, sy, input bit typed,
			input logic [PIXEL_W-1:0] tx, ty);
		pixel_t res;
		in_valid <= 1'b1;
		x_sample <= sx;
		y_sample <= sy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (trim_and_map(sx, sy, res)) begin
			if (typed) begin
				res.px = tx;
				res.py = ty;
			end
			pixel_q.push_back(res);
		end
		if (src_rate != 0 && $urandom_range(0, 99) < src_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_GAIN_X:   cal_gain_x = data;
			REG_OFFSET_X: cal_off_x  = data[OFFSET_W-1:0];
			REG_GAIN_Y:   cal_gain_y = data;
			REG_OFFSET_Y: cal_off_y  = data[OFFSET_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering and let every pending pixel pair drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (IDLE_PAD) @(posedge clk);
	endtask

	// result side: random stalls, plus a long hold-off when asked
	initial begin : sink
		int burst;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (sink_rate != 0 && $urandom_range(0, 99) < sink_rate) begin
				burst = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (burst - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// compare each pixel transfer with the oldest prediction
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected pixel pair x=%0d y=%0d at %0t",
						screen_x, screen_y, $time);
				mismatches++;
			end else begin
				want = pixel_q.pop_front();
				if (screen_x !== want.px || screen_y !== want.py) begin
					if (mismatches < 10)
						$display("pixel mismatch: expected x=%0d y=%0d, got x=%0d y=%0d at %0t",
							want.px, want.py, screen_x, screen_y, $time);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL touch_trimmed_mean_mapper");
			$finish;
		end
	end

	initial begin : stimulus
		int  rand_sent;
		int  phase;
		int  n;
		int  style;
		int  mode;
		int  base_x;
		int  base_y;
		int  spread;
		int  g;
		int  o;
		bit  calm;
		bit  quiet;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_GAIN_X;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		x_sample  <= '0;
		y_sample  <= '0;

		// window at reset calibration, every sample at the rails
		for (int i = 0; i < 9; i++)
			add_pair(12'hFFF, 12'h000);
		add_pair(12'hFFF, 12'h000, 1'b1, 10'd1023, 10'd0);
		// rail calibration values, and a write to an index with no register
		add_reg(REG_GAIN_X, 18'h20000);
		add_reg(REG_OFFSET_X, 18'h0FFFF);
		add_reg(REG_GAIN_Y, 18'h1FFFF);
		add_reg(REG_OFFSET_Y, 18'h10000);
		add_reg(REG_UNUSED, 18'h3FFFF);
		// single min and max; x mean maps a sixteenth of a pixel below zero
		add_pair(12'h000, 12'hFFF);
		add_pair(12'hFFF, 12'h000);
		for (int i = 0; i < 8; i++)
			add_pair(12'd2048, 12'(1000 + 300 * i));
		// unit gain, x offset of minus one pixel with the unused top data bit set
		add_reg(REG_GAIN_X, 18'd65536);
		add_reg(REG_OFFSET_X, 18'h3FFF0);
		add_reg(REG_GAIN_Y, 18'd65536);
		add_reg(REG_OFFSET_Y, 18'd0);
		// half a window, finished under the first random calibration
		add_pair(12'h001, 12'hFFE);
		add_pair(12'hFFE, 12'h001);
		add_pair(12'd2730, 12'd1365);
		add_pair(12'd1365, 12'd2730);
		add_pair(12'h800, 12'h7FF);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		src_rate  = 20;
		sink_rate = 20;
		quiet     = 1'b1;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				if (!quiet) settle();
				quiet = 1'b1;
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_pair(plan[i].sx, plan[i].sy, plan[i].typed, plan[i].tx, plan[i].ty);
				quiet = 1'b0;
			end
		end

		// random phases
		rand_sent = 0;
		phase     = 0;
		while (rand_sent < RAND_PAIRS) begin
			calm = (rand_sent >= RAND_PAIRS - CALM_PAIRS);

			// new calibration, often in the middle of a window
			if (phase == 0 || $urandom_range(0, 2) == 0) begin
				settle();
				style = $urandom_range(0, 3);
				for (int ax = 0; ax < 2; ax++) begin
					case (style)
						0: begin
							case ($urandom_range(0, 3))
								0: g = -131072;
								1: g = 131071;
								2: g = 0;
								default: g = 65536;
							endcase
							case ($urandom_range(0, 2))
								0: o = -65536;
								1: o = 65535;
								default: o = 0;
							endcase
						end
						3: begin
							g = $urandom;
							o = $urandom;
						end
						default: begin
							// plausible panel calibration, sometimes a mirrored axis
							g = $urandom_range(8000, 26000);
							o = int'($urandom_range(0, 16000)) - 8000;
							if ($urandom_range(0, 3) == 0) begin
								g = -g;
								o = 16 * $urandom_range(600, 1100);
							end
						end
					endcase
					write_reg(ax ? REG_GAIN_Y : REG_GAIN_X, 18'(g));
					write_reg(ax ? REG_OFFSET_Y : REG_OFFSET_X, 18'(o));
				end
				if ($urandom_range(0, 2) == 0)
					write_reg(CFG_IDX_W'($urandom_range(REG_OFFSET_Y + 1, (1 << CFG_IDX_W) - 1)),
						CFG_W'($urandom));
			end

			// idling on each side for this phase
			if (calm) begin
				src_rate  = 0;
				sink_rate = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: src_rate = 0;
					1: src_rate = 10;
					default: src_rate = 40;
				endcase
				case ($urandom_range(0, 2))
					0: sink_rate = 0;
					1: sink_rate = 10;
					default: sink_rate = 40;
				endcase
			end

			n = $urandom_range(5, 60);
			// back pressure: results held off while pairs keep coming
			if (!calm && (phase == 2 || $urandom_range(0, 7) == 0)) begin
				hold_left = $urandom_range(100, 160);
				src_rate  = 0;
				n         = $urandom_range(50, 60);
			end
			if (n > RAND_PAIRS - rand_sent)
				n = RAND_PAIRS - rand_sent;

			mode   = $urandom_range(0, 2);
			base_x = $urandom_range(0, 4095);
			base_y = $urandom_range(0, 4095);
			spread = $urandom_range(0, 80);
			for (int i = 0; i < n; i++) begin
				send_pair(draw_sample(mode, base_x, spread), draw_sample(mode, base_y, spread),
					1'b0, 10'd0, 10'd0);
				rand_sent++;
			end
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("PASS touch_trimmed_mean_mapper");
		else
			$display("FAIL touch_trimmed_mean_mapper");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ttmm_pkg.sv
rtl/core/ttmm_lane.sv
rtl/core/ttmm_map.sv
rtl/core/touch_trimmed_mean_mapper.sv
rtl/core/ttmm_checker.sv
dv/tb_touch_trimmed_mean_mapper.sv
